// File: rtl/jexif_pkg.sv
// Types, phase codes and helpers shared by the Exif orientation parser.
// No dependencies; every other file of the parser uses this package.
`timescale 1ns / 1ps
`default_nettype none

package jexif_pkg;

    localparam int DATA_W   = 8;
    localparam int ORIENT_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  MARKER_SOI    = 8'hD8;
    localparam logic [7:0]  MARKER_EOI    = 8'hD9;
    localparam logic [7:0]  MARKER_SOS    = 8'hDA;
    localparam logic [7:0]  MARKER_APP1   = 8'hE1;
    localparam logic [7:0]  BYTE_ORDER_II = 8'h49;
    localparam logic [15:0] TAG_ORIENT    = 16'h0112;
    localparam logic [31:0] TIFF_MAGIC    = 32'd42;
    localparam logic [15:0] ORIENT_DEFAULT = 16'd1;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_JPEG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_TAG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TIFF = 2'd3;

    typedef enum logic [12:0] {
        PH_SOI0  = 13'b0_0000_0000_0001,
        PH_SOI1  = 13'b0_0000_0000_0010,
        PH_MARK  = 13'b0_0000_0000_0100,
        PH_CODE  = 13'b0_0000_0000_1000,
        PH_LENHI = 13'b0_0000_0001_0000,
        PH_LENLO = 13'b0_0000_0010_0000,
        PH_SKIP  = 13'b0_0000_0100_0000,
        PH_EXIF  = 13'b0_0000_1000_0000,
        PH_TIFF  = 13'b0_0001_0000_0000,
        PH_SEEK  = 13'b0_0010_0000_0000,
        PH_COUNT = 13'b0_0100_0000_0000,
        PH_ENTRY = 13'b0_1000_0000_0000,
        PH_DONE  = 13'b1_0000_0000_0000
    } phase_t;

    typedef struct packed {
        logic                valid;
        logic [ORIENT_W-1:0] orientation;
        logic [STATUS_W-1:0] status;
    } result_t;

    // "Exif\0\0" header that opens an Exif APP1 segment
    function automatic logic [7:0] exif_sig(input logic [2:0] idx);
        logic [7:0] sig;
        case (idx)
            3'd0:    sig = 8'h45;
            3'd1:    sig = 8'h78;
            3'd2:    sig = 8'h69;
            3'd3:    sig = 8'h66;
            default: sig = 8'h00;
        endcase
        return sig;
    endfunction

    // Fold one byte into a multi-byte field in the file's byte order
    function automatic logic [31:0] take(input logic [31:0] acc, input logic [7:0] b,
                                         input logic [1:0] k, input logic little);
        logic [31:0] res;
        if (little)
            res = acc | ({24'd0, b} << {k, 3'b000});
        else
            res = {acc[23:0], b};
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/jexif_parser.sv
// Per-byte parse state and next-state logic of the Exif orientation parser.
// Depends on jexif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jexif_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output jexif_pkg::result_t         result
);

    jexif_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  marker_code_reg, marker_code_next;
    logic [15:0] segment_length_reg, segment_length_next;
    logic [15:0] segment_position_reg, segment_position_next;
    logic        little_endian_reg, little_endian_next;
    logic [15:0] directory_position_reg, directory_position_next;
    logic [15:0] entries_left_reg, entries_left_next;
    logic [3:0]  entry_byte_index_reg, entry_byte_index_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic        tag_matched_reg, tag_matched_next;

    always_comb
    begin
        logic [15:0] pos_inc;
        logic [15:0] len_full;
        logic [15:0] len_net;
        logic [15:0] el;
        logic [31:0] fs;
        logic [2:0]  idx;
        phase_next              = phase_reg;
        marker_code_next        = marker_code_reg;
        segment_length_next     = segment_length_reg;
        segment_position_next   = segment_position_reg;
        little_endian_next      = little_endian_reg;
        directory_position_next = directory_position_reg;
        entries_left_next       = entries_left_reg;
        entry_byte_index_next   = entry_byte_index_reg;
        field_shift_next        = field_shift_reg;
        tag_matched_next        = tag_matched_reg;
        result.valid            = 1'b0;
        result.orientation      = jexif_pkg::ORIENT_DEFAULT;
        result.status           = jexif_pkg::STATUS_NO_TAG;
        pos_inc  = segment_position_reg + 16'd1;
        len_full = {segment_length_reg[15:8], data_byte};
        len_net  = len_full - 16'd2;
        el       = entries_left_reg - 16'd1;
        fs       = 32'd0;
        idx      = segment_position_reg[2:0];

        if (accept)
        begin
            unique case (phase_reg)
                jexif_pkg::PH_SOI0:
                begin
                    if (data_byte != jexif_pkg::MARKER_PREFIX)
                    begin
                        result.valid  = 1'b1;
                        result.status = jexif_pkg::STATUS_NOT_JPEG;
                        phase_next    = jexif_pkg::PH_DONE;
                    end
                    else
                        phase_next = jexif_pkg::PH_SOI1;
                end
                jexif_pkg::PH_SOI1:
                begin
                    if (data_byte != jexif_pkg::MARKER_SOI)
                    begin
                        result.valid  = 1'b1;
                        result.status = jexif_pkg::STATUS_NOT_JPEG;
                        phase_next    = jexif_pkg::PH_DONE;
                    end
                    else
                        phase_next = jexif_pkg::PH_MARK;
                end
                jexif_pkg::PH_MARK:
                begin
                    if (data_byte != jexif_pkg::MARKER_PREFIX)
                    begin
                        result.valid = 1'b1;
                        phase_next   = jexif_pkg::PH_DONE;
                    end
                    else
                        phase_next = jexif_pkg::PH_CODE;
                end
                jexif_pkg::PH_CODE:
                begin
                    marker_code_next = data_byte;
                    if (data_byte == jexif_pkg::MARKER_EOI || data_byte == jexif_pkg::MARKER_SOS)
                    begin
                        result.valid = 1'b1;
                        phase_next   = jexif_pkg::PH_DONE;
                    end
                    else
                        phase_next = jexif_pkg::PH_LENHI;
                end
                jexif_pkg::PH_LENHI:
                begin
                    segment_length_next = {data_byte, 8'd0};
                    phase_next          = jexif_pkg::PH_LENLO;
                end
                jexif_pkg::PH_LENLO:
                begin
                    if (len_full < 16'd2)
                    begin
                        segment_length_next = len_full;
                        result.valid        = 1'b1;
                        phase_next          = jexif_pkg::PH_DONE;
                    end
                    else
                    begin
                        // hold the length net of the two length bytes
                        segment_length_next   = len_net;
                        segment_position_next = 16'd0;
                        if (marker_code_reg == jexif_pkg::MARKER_APP1 && len_net >= 16'd16)
                            phase_next = jexif_pkg::PH_EXIF;
                        else if (len_net == 16'd0)
                            phase_next = jexif_pkg::PH_MARK;
                        else
                            phase_next = jexif_pkg::PH_SKIP;
                    end
                end
                jexif_pkg::PH_SKIP:
                begin
                    segment_position_next = pos_inc;
                    phase_next = (pos_inc >= segment_length_reg) ? jexif_pkg::PH_MARK
                                                                 : jexif_pkg::PH_SKIP;
                end
                jexif_pkg::PH_EXIF:
                begin
                    segment_position_next = pos_inc;
                    if (segment_position_reg > 16'd5 || data_byte != jexif_pkg::exif_sig(idx))
                        phase_next = (pos_inc >= segment_length_reg) ? jexif_pkg::PH_MARK
                                                                     : jexif_pkg::PH_SKIP;
                    else if (idx == 3'd5)
                        phase_next = jexif_pkg::PH_TIFF;
                end
                jexif_pkg::PH_TIFF:
                begin
                    segment_position_next = pos_inc;
                    if (segment_position_reg == 16'd6)
                        little_endian_next = (data_byte == jexif_pkg::BYTE_ORDER_II);
                    else if (segment_position_reg == 16'd7)
                        little_endian_next = little_endian_reg &&
                                             (data_byte == jexif_pkg::BYTE_ORDER_II);
                    else if (segment_position_reg == 16'd8)
                        field_shift_next = jexif_pkg::take(32'd0, data_byte, 2'd0,
                                                           little_endian_reg);
                    else if (segment_position_reg == 16'd9)
                    begin
                        fs = jexif_pkg::take(field_shift_reg, data_byte, 2'd1, little_endian_reg);
                        field_shift_next = fs;
                        if (fs != jexif_pkg::TIFF_MAGIC)
                        begin
                            result.valid  = 1'b1;
                            result.status = jexif_pkg::STATUS_BAD_TIFF;
                            phase_next    = jexif_pkg::PH_DONE;
                        end
                    end
                    else if (segment_position_reg == 16'd10)
                        field_shift_next = jexif_pkg::take(32'd0, data_byte, 2'd0,
                                                           little_endian_reg);
                    else if (segment_position_reg == 16'd11 || segment_position_reg == 16'd12)
                        field_shift_next = jexif_pkg::take(field_shift_reg, data_byte,
                                                           segment_position_reg[1:0] + 2'd2,
                                                           little_endian_reg);
                    else
                    begin
                        // last offset byte: check the IFD0 offset against header and segment
                        fs = jexif_pkg::take(field_shift_reg, data_byte, 2'd3, little_endian_reg);
                        field_shift_next = fs;
                        if (fs < 32'd8)
                        begin
                            result.valid  = 1'b1;
                            result.status = jexif_pkg::STATUS_BAD_TIFF;
                            phase_next    = jexif_pkg::PH_DONE;
                        end
                        else if ({1'b0, fs} + 33'd8 > {17'd0, segment_length_reg})
                        begin
                            result.valid = 1'b1;
                            phase_next   = jexif_pkg::PH_DONE;
                        end
                        else
                        begin
                            directory_position_next = fs[15:0] + 16'd6;
                            entry_byte_index_next   = 4'd0;
                            phase_next = (fs[15:0] == 16'd8) ? jexif_pkg::PH_COUNT
                                                             : jexif_pkg::PH_SEEK;
                        end
                    end
                end
                jexif_pkg::PH_SEEK:
                begin
                    segment_position_next = pos_inc;
                    if (pos_inc >= directory_position_reg)
                    begin
                        phase_next            = jexif_pkg::PH_COUNT;
                        entry_byte_index_next = 4'd0;
                    end
                end
                jexif_pkg::PH_COUNT:
                begin
                    segment_position_next = pos_inc;
                    if (entry_byte_index_reg == 4'd0)
                    begin
                        field_shift_next      = {24'd0, data_byte};
                        entry_byte_index_next = 4'd1;
                    end
                    else
                    begin
                        fs = jexif_pkg::take(field_shift_reg, data_byte, 2'd1, little_endian_reg);
                        field_shift_next  = fs;
                        entries_left_next = fs[15:0];
                        if (fs[15:0] == 16'd0 ||
                            {1'b0, pos_inc} + 17'd12 > {1'b0, segment_length_reg})
                            phase_next = (pos_inc >= segment_length_reg) ? jexif_pkg::PH_MARK
                                                                         : jexif_pkg::PH_SKIP;
                        else
                        begin
                            phase_next            = jexif_pkg::PH_ENTRY;
                            entry_byte_index_next = 4'd0;
                        end
                    end
                end
                jexif_pkg::PH_ENTRY:
                begin
                    segment_position_next = pos_inc;
                    if (entry_byte_index_reg == 4'd0 || entry_byte_index_reg == 4'd8)
                        field_shift_next = {24'd0, data_byte};
                    else if (entry_byte_index_reg == 4'd1)
                    begin
                        fs = jexif_pkg::take(field_shift_reg, data_byte, 2'd1, little_endian_reg);
                        field_shift_next = fs;
                        tag_matched_next = ({16'd0, jexif_pkg::TAG_ORIENT} == fs);
                    end
                    else if (entry_byte_index_reg == 4'd9)
                    begin
                        fs = jexif_pkg::take(field_shift_reg, data_byte, 2'd1, little_endian_reg);
                        field_shift_next = fs;
                    end

                    if (entry_byte_index_reg == 4'd9 && tag_matched_reg)
                    begin
                        result.valid       = 1'b1;
                        result.orientation = fs[15:0];
                        result.status      = jexif_pkg::STATUS_FOUND;
                        phase_next         = jexif_pkg::PH_DONE;
                    end
                    else if (entry_byte_index_reg >= 4'd11)
                    begin
                        // entry done: start the next one or drop the rest of the segment
                        entries_left_next = el;
                        if (el == 16'd0 ||
                            {1'b0, pos_inc} + 17'd12 > {1'b0, segment_length_reg})
                            phase_next = (pos_inc >= segment_length_reg) ? jexif_pkg::PH_MARK
                                                                         : jexif_pkg::PH_SKIP;
                        else
                        begin
                            phase_next            = jexif_pkg::PH_ENTRY;
                            entry_byte_index_next = 4'd0;
                        end
                    end
                    else
                        entry_byte_index_next = entry_byte_index_reg + 4'd1;
                end
                jexif_pkg::PH_DONE:
                begin
                    phase_next = jexif_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = jexif_pkg::PH_SOI0;
                end
            endcase

            if (last_byte)
            begin
                if (!result.valid && phase_next != jexif_pkg::PH_DONE)
                begin
                    result.valid = 1'b1;
                    result.status = (phase_next == jexif_pkg::PH_SOI0 ||
                                     phase_next == jexif_pkg::PH_SOI1)
                                    ? jexif_pkg::STATUS_NOT_JPEG : jexif_pkg::STATUS_NO_TAG;
                end
                // end of file: start over for the next one
                phase_next              = jexif_pkg::PH_SOI0;
                marker_code_next        = 8'd0;
                segment_length_next     = 16'd0;
                segment_position_next   = 16'd0;
                little_endian_next      = 1'b0;
                directory_position_next = 16'd0;
                entries_left_next       = 16'd0;
                entry_byte_index_next   = 4'd0;
                field_shift_next        = 32'd0;
                tag_matched_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= jexif_pkg::PH_SOI0;
            marker_code_reg        <= 8'd0;
            segment_length_reg     <= 16'd0;
            segment_position_reg   <= 16'd0;
            little_endian_reg      <= 1'b0;
            directory_position_reg <= 16'd0;
            entries_left_reg       <= 16'd0;
            entry_byte_index_reg   <= 4'd0;
            field_shift_reg        <= 32'd0;
            tag_matched_reg        <= 1'b0;
        end
        else
        begin
            phase_reg              <= phase_next;
            marker_code_reg        <= marker_code_next;
            segment_length_reg     <= segment_length_next;
            segment_position_reg   <= segment_position_next;
            little_endian_reg      <= little_endian_next;
            directory_position_reg <= directory_position_next;
            entries_left_reg       <= entries_left_next;
            entry_byte_index_reg   <= entry_byte_index_next;
            field_shift_reg        <= field_shift_next;
            tag_matched_reg        <= tag_matched_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jexif_out_reg.sv
// Result register of the Exif orientation parser, holds one result until taken.
// Depends on jexif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jexif_out_reg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire jexif_pkg::result_t             result,
    output logic                                room,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [jexif_pkg::ORIENT_W-1:0]      m_tdata,
    output logic [jexif_pkg::STATUS_W-1:0]      m_tuser
);

    logic                           valid_reg;
    logic [jexif_pkg::ORIENT_W-1:0] orient_reg;
    logic [jexif_pkg::STATUS_W-1:0] status_reg;

    // a new result may land when the register is empty or drains this cycle
    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = orient_reg;
    assign m_tuser  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (room)
            valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (room && result.valid)
        begin
            orient_reg <= result.orientation;
            status_reg <= result.status;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jpeg_exif_orientation_parser_core.sv
// Top level of the JPEG Exif orientation parser.
// Depends on jexif_pkg, jexif_parser and jexif_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a JPEG file one byte per item (s_tlast on the final byte) and returns exactly one
// result per file: the IFD0 orientation tag value with status 0, or orientation 1 with
// status 1 (not JPEG), 2 (no orientation tag) or 3 (invalid TIFF header). The parse state
// updates at the edge that accepts a byte, and any result it causes sits in the output
// register on the next cycle. Bytes after the result are consumed and ignored up to s_tlast;
// the byte after s_tlast starts a new file. s_tready falls only while a result waits in the
// output register and m_tready is low.
module jpeg_exif_orientation_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] orientation
    output logic [1:0]       m_tuser    // [1:0] status
);

    jexif_pkg::result_t result;
    logic               room;

    assign s_tready = room;

    jexif_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_tvalid && room),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (result)
    );

    jexif_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for jpeg_exif_orientation_parser_core: streams whole JPEG files byte by byte
// and checks each orientation result against an in-bench parser. Depends on jexif_pkg.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [15:0] orientation;
        logic [1:0]  status;
    } tag_result_t;

    // "Exif\0\0", first character in the top byte
    localparam logic [47:0] EXIF_ID = 48'h4578_6966_0000;
    // marker codes used for segments that get passed over
    localparam logic [79:0] FILLER_CODES =
        {8'hE0, 8'hE2, 8'hEC, 8'hED, 8'hEE, 8'hDB, 8'hC0, 8'hC4, 8'hFE, 8'hE1};

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    bit send_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;

    tag_result_t expected_tags[$];
    tag_result_t want;
    logic [7:0]  img[$];        // bytes of the file being built

    int files_sent   = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;

    // parse state of the in-bench model
    jexif_pkg::phase_t walk_phase;
    bit          answered;
    logic [7:0]  seg_marker;
    logic [15:0] seg_len;
    logic [15:0] seg_pos;
    bit          little_order;
    logic [31:0] ifd_pos;
    logic [15:0] ifd_left;
    logic [3:0]  entry_idx;
    logic [31:0] field_acc;
    bit          tag_hit;

    jpeg_exif_orientation_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------- parser model

    task automatic restart_file();
        walk_phase   = jexif_pkg::PH_SOI0;
        answered     = 1'b0;
        seg_marker   = 8'h00;
        seg_len      = 16'h0000;
        seg_pos      = 16'h0000;
        little_order = 1'b0;
        ifd_pos      = 32'h0;
        ifd_left     = 16'h0000;
        entry_idx    = 4'h0;
        field_acc    = 32'h0;
        tag_hit      = 1'b0;
    endtask

    task automatic emit_tag(input logic [15:0] orient, input logic [1:0] st);
        tag_result_t r;
        r.orientation = orient;
        r.status      = st;
        expected_tags = {expected_tags, r};
        answered   = 1'b1;
        walk_phase = jexif_pkg::PH_DONE;
    endtask

    task automatic fold_field(input logic [7:0] b, input int k);
        if (little_order)
            field_acc = field_acc | (32'(b) << (8 * k));
        else
            field_acc = {field_acc[23:0], b};
    endtask

    task automatic skip_segment_rest();
        if (seg_pos >= seg_len)
            walk_phase = jexif_pkg::PH_MARK;
        else
            walk_phase = jexif_pkg::PH_SKIP;
    endtask

    task automatic open_ifd_entry();
        if (ifd_left == 16'd0 || ({1'b0, seg_pos} + 17'd12) > {1'b0, seg_len})
            skip_segment_rest();
        else
        begin
            walk_phase = jexif_pkg::PH_ENTRY;
            entry_idx  = 4'd0;
        end
    endtask

    task automatic parse_exif_byte(input logic [7:0] b, input logic eof);
        logic [15:0] pos0;
        logic [32:0] reach;
        if (!answered)
        begin
            case (walk_phase)
                jexif_pkg::PH_SOI0:
                    if (b != jexif_pkg::MARKER_PREFIX)
                        emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NOT_JPEG);
                    else walk_phase = jexif_pkg::PH_SOI1;
                jexif_pkg::PH_SOI1:
                    if (b != jexif_pkg::MARKER_SOI)
                        emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NOT_JPEG);
                    else walk_phase = jexif_pkg::PH_MARK;
                jexif_pkg::PH_MARK:
                    if (b != jexif_pkg::MARKER_PREFIX)
                        emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NO_TAG);
                    else walk_phase = jexif_pkg::PH_CODE;
                jexif_pkg::PH_CODE:
                begin
                    seg_marker = b;
                    if (b == jexif_pkg::MARKER_EOI || b == jexif_pkg::MARKER_SOS)
                        emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NO_TAG);
                    else
                        walk_phase = jexif_pkg::PH_LENHI;
                end
                jexif_pkg::PH_LENHI:
                begin
                    seg_len    = {b, 8'h00};
                    walk_phase = jexif_pkg::PH_LENLO;
                end
                jexif_pkg::PH_LENLO:
                begin
                    seg_len = seg_len | {8'h00, b};
                    if (seg_len < 16'd2)
                        emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NO_TAG);
                    else
                    begin
                        seg_len = seg_len - 16'd2;
                        seg_pos = 16'd0;
                        if (seg_marker == jexif_pkg::MARKER_APP1 && seg_len >= 16'd16)
                            walk_phase = jexif_pkg::PH_EXIF;
                        else
                            skip_segment_rest();
                    end
                end
                jexif_pkg::PH_SKIP:
                begin
                    seg_pos = seg_pos + 16'd1;
                    skip_segment_rest();
                end
                jexif_pkg::PH_EXIF:
                begin
                    pos0    = seg_pos;
                    seg_pos = seg_pos + 16'd1;
                    if (pos0 > 16'd5)
                        skip_segment_rest();
                    else if (b != EXIF_ID[8 * (5 - pos0) +: 8])
                        skip_segment_rest();
                    else if (pos0 == 16'd5)
                        walk_phase = jexif_pkg::PH_TIFF;
                end
                jexif_pkg::PH_TIFF:
                begin
                    pos0    = seg_pos;
                    seg_pos = seg_pos + 16'd1;
                    case (pos0)
                        16'd6: little_order = (b == jexif_pkg::BYTE_ORDER_II);
                        16'd7: little_order = little_order && (b == jexif_pkg::BYTE_ORDER_II);
                        16'd8:
                        begin
                            field_acc = 32'h0;
                            fold_field(b, 0);
                        end
                        16'd9:
                        begin
                            fold_field(b, 1);
                            if (field_acc != jexif_pkg::TIFF_MAGIC)
                                emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_BAD_TIFF);
                        end
                        16'd10:
                        begin
                            field_acc = 32'h0;
                            fold_field(b, 0);
                        end
                        16'd11: fold_field(b, 1);
                        16'd12: fold_field(b, 2);
                        default:
                        begin
                            fold_field(b, 3);
                            reach = {1'b0, field_acc} + 33'd8;
                            if (field_acc < 32'd8)
                                emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_BAD_TIFF);
                            else if (reach > {17'd0, seg_len})
                                emit_tag(jexif_pkg::ORIENT_DEFAULT, jexif_pkg::STATUS_NO_TAG);
                            else
                            begin
                                ifd_pos   = field_acc + 32'd6;
                                entry_idx = 4'd0;
                                if (ifd_pos == 32'd14)
                                    walk_phase = jexif_pkg::PH_COUNT;
                                else
                                    walk_phase = jexif_pkg::PH_SEEK;
                            end
                        end
                    endcase
                end
                jexif_pkg::PH_SEEK:
                begin
                    seg_pos = seg_pos + 16'd1;
                    if ({16'd0, seg_pos} >= ifd_pos)
                    begin
                        walk_phase = jexif_pkg::PH_COUNT;
                        entry_idx  = 4'd0;
                    end
                end
                jexif_pkg::PH_COUNT:
                begin
                    seg_pos = seg_pos + 16'd1;
                    if (entry_idx == 4'd0)
                    begin
                        field_acc = 32'h0;
                        fold_field(b, 0);
                        entry_idx = 4'd1;
                    end
                    else
                    begin
                        fold_field(b, 1);
                        ifd_left = field_acc[15:0];
                        open_ifd_entry();
                    end
                end
                jexif_pkg::PH_ENTRY:
                begin
                    seg_pos = seg_pos + 16'd1;
                    if (entry_idx == 4'd0 || entry_idx == 4'd8)
                    begin
                        field_acc = 32'h0;
                        fold_field(b, 0);
                    end
                    else if (entry_idx == 4'd1)
                    begin
                        fold_field(b, 1);
                        tag_hit = (field_acc == {16'h0, jexif_pkg::TAG_ORIENT});
                    end
                    else if (entry_idx == 4'd9)
                    begin
                        fold_field(b, 1);
                        if (tag_hit)
                            emit_tag(field_acc[15:0], jexif_pkg::STATUS_FOUND);
                    end
                    if (!answered)
                    begin
                        if (entry_idx >= 4'd11)
                        begin
                            ifd_left = ifd_left - 16'd1;
                            open_ifd_entry();
                        end
                        else
                            entry_idx = entry_idx + 4'd1;
                    end
                end
                default: ;
            endcase
        end
        if (eof)
        begin
            if (!answered)
                emit_tag(jexif_pkg::ORIENT_DEFAULT,
                         (walk_phase == jexif_pkg::PH_SOI0 || walk_phase == jexif_pkg::PH_SOI1) ?
                         jexif_pkg::STATUS_NOT_JPEG : jexif_pkg::STATUS_NO_TAG);
            restart_file();
        end
    endtask

    // ---------------------------------------------------------------- file builders

    task automatic add_byte(input logic [7:0] b);
        img = {img, b};
    endtask

    task automatic put_u16(input logic [15:0] v, input bit le_o);
        if (le_o)
        begin
            add_byte(v[7:0]);
            add_byte(v[15:8]);
        end
        else
        begin
            add_byte(v[15:8]);
            add_byte(v[7:0]);
        end
    endtask

    task automatic put_segment(input logic [7:0] code, input int n);
        add_byte(jexif_pkg::MARKER_PREFIX);
        add_byte(code);
        put_u16(16'(n + 2), 1'b0);
        repeat (n) add_byte(8'($urandom));
    endtask

    // APP1 Exif segment with an IFD0 of n_ent entries; the orientation tag sits at
    // entry tag_at (none when out of range); len_cut shortens the declared length
    task automatic put_exif_app1(input bit le_o, input logic [15:0] magic,
                                 input logic [31:0] ifd_off, input int n_ent,
                                 input int tag_at, input logic [15:0] orient_v,
                                 input int len_cut);
        int pad;
        int data_len;
        pad      = (ifd_off >= 32'd8 && ifd_off < 32'd40) ? int'(ifd_off) - 8 : 0;
        data_len = 14 + pad + 2 + 12 * n_ent + 4;
        add_byte(jexif_pkg::MARKER_PREFIX);
        add_byte(jexif_pkg::MARKER_APP1);
        put_u16(16'(data_len + 2 - len_cut), 1'b0);
        for (int k = 0; k < 6; k++)
            add_byte(EXIF_ID[8 * (5 - k) +: 8]);
        if (le_o)
            put_u16(16'h4949, 1'b0);
        else
            put_u16(16'h4D4D, 1'b0);
        put_u16(magic, le_o);
        if (le_o)
        begin
            put_u16(ifd_off[15:0], 1'b1);
            put_u16(ifd_off[31:16], 1'b1);
        end
        else
        begin
            put_u16(ifd_off[31:16], 1'b0);
            put_u16(ifd_off[15:0], 1'b0);
        end
        repeat (pad) add_byte(8'($urandom));
        put_u16(16'(n_ent), le_o);
        for (int i = 0; i < n_ent; i++)
        begin
            if (i == tag_at)
            begin
                put_u16(jexif_pkg::TAG_ORIENT, le_o);
                put_u16(16'd3, le_o);
                put_u16(le_o ? 16'd1 : 16'd0, le_o);
                put_u16(le_o ? 16'd0 : 16'd1, le_o);
                put_u16(orient_v, le_o);
                put_u16(16'd0, le_o);
            end
            else
                repeat (12) add_byte(8'($urandom));
        end
        repeat (4) add_byte(8'h00);
    endtask

    task automatic make_random_file();
        int          kind;
        int          n;
        bit          le_o;
        logic [15:0] magic;
        logic [31:0] off;
        int          n_ent;
        int          tag_at;
        logic [15:0] ov;
        int          cut;
        img.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // noise, sometimes behind a valid start marker
            if ($urandom_range(0, 1))
                img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
            repeat ($urandom_range(1, 16)) add_byte(8'($urandom));
        end
        else
        begin
            img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
            repeat ($urandom_range(0, 2))
                put_segment(FILLER_CODES[8 * $urandom_range(0, 9) +: 8], $urandom_range(0, 18));
            if (kind != 1)
            begin
                le_o  = $urandom_range(0, 1);
                magic = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 63)) :
                        16'(jexif_pkg::TIFF_MAGIC);
                case ($urandom_range(0, 9))
                    0:       off = 32'($urandom_range(0, 7));
                    1:       off = $urandom;
                    default: off = 32'($urandom_range(8, 14));
                endcase
                n_ent  = $urandom_range(0, 3);
                tag_at = ($urandom_range(0, 4) == 0) ? -1 : int'($urandom_range(0, n_ent));
                ov     = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'($urandom_range(1, 8));
                cut    = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 14)) : 0;
                put_exif_app1(le_o, magic, off, n_ent, tag_at, ov, cut);
            end
            if ($urandom_range(0, 1))
            begin
                add_byte(jexif_pkg::MARKER_PREFIX);
                add_byte(jexif_pkg::MARKER_SOS);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            end
            else
            begin
                add_byte(jexif_pkg::MARKER_PREFIX);
                add_byte(jexif_pkg::MARKER_EOI);
            end
        end
        // corrupt or truncate now and then
        if ($urandom_range(0, 5) == 0)
            img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, img.size());
            while (img.size() > n)
                void'(img.pop_back());
        end
    endtask

    // ---------------------------------------------------------------- drive and check

    task automatic send_item(input logic [7:0] d, input logic eof);
        int gap;
        if (send_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        parse_exif_byte(d, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (img[i])
            send_item(img[i], i == img.size() - 1);
        files_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tags.size() != 0) @(posedge clk);
    endtask

    task automatic log_mismatch(input string field, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, field, exp_v, act_v);
    endtask

    initial
    begin : sink_side
        int   span;
        logic rdy;
        forever
        begin
            if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                span = $urandom_range(1, 15);
                rdy  = 1'b0;
            end
            else
            begin
                span = $urandom_range(1, 12);
                rdy  = 1'b1;
            end
            repeat (span)
            begin
                m_tready <= rdy || !sink_idle_en;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_tags.size() == 0)
                log_mismatch("unexpected result, orientation", 16'h0, m_tdata);
            else
            begin
                want = expected_tags.pop_front();
                if (m_tdata !== want.orientation)
                    log_mismatch("orientation", want.orientation, m_tdata);
                if (m_tuser !== want.status)
                    log_mismatch("status", {14'd0, want.status}, {14'd0, m_tuser});
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_marker_errors();
        img = {8'h00};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, 8'hFF, 8'h00};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, 8'h12, 8'hFF};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               jexif_pkg::MARKER_EOI};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               jexif_pkg::MARKER_SOS, 8'h00};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               8'hE0, 8'h00, 8'h01};
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               8'hE0, 8'h00, 8'h00, 8'hAA};
        send_file();
        // file ends inside a segment without a result
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               8'hE0, 8'h00, 8'h02, jexif_pkg::MARKER_PREFIX, 8'hC0, 8'h00, 8'h04, 8'hAA};
        send_file();
    endtask

    task automatic test_exif_parsing();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b1, 16'd42, 32'd8, 1, 0, 16'hFFFF, 0);
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b0, 16'd42, 32'd10, 3, 2, 16'h0000, 0);
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b1, 16'd43, 32'd8, 1, 0, 16'd6, 0);
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b0, 16'd42, 32'd0, 1, 0, 16'd6, 0);
        send_file();
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b1, 16'd42, 32'd7, 1, 0, 16'd6, 0);
        send_file();
        // IFD0 far past the end of the segment
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b0, 16'd42, 32'hFFFF_FFF0, 1, 0, 16'd3, 0);
        send_file();
        // short APP1 and non-Exif APP1 are passed over, the walk goes on
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_segment(jexif_pkg::MARKER_APP1, 15);
        put_segment(jexif_pkg::MARKER_APP1, 20);
        put_exif_app1(1'b1, 16'd42, 32'd12, 2, 1, 16'd8, 0);
        send_file();
        // no orientation tag in IFD0
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b0, 16'd42, 32'd8, 2, -1, 16'd5, 0);
        add_byte(jexif_pkg::MARKER_PREFIX);
        add_byte(jexif_pkg::MARKER_EOI);
        send_file();
        // second entry runs past the declared segment end
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b1, 16'd42, 32'd8, 2, 1, 16'd7, 8);
        send_file();
        // tag found, then trailing bytes that must be ignored
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI};
        put_exif_app1(1'b0, 16'd42, 32'd8, 1, 0, 16'd3, 0);
        img = {img, jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               jexif_pkg::MARKER_APP1, 8'h00};
        send_file();
        // length with a nonzero high byte, file ends inside the segment
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               8'hE0, 8'h12, 8'h34, 8'hAA, 8'hBB};
        send_file();
        // long Exif APP1, file ends inside the TIFF header
        img = {jexif_pkg::MARKER_PREFIX, jexif_pkg::MARKER_SOI, jexif_pkg::MARKER_PREFIX,
               jexif_pkg::MARKER_APP1, 8'h01, 8'h00};
        for (int k = 0; k < 6; k++)
            add_byte(EXIF_ID[8 * (5 - k) +: 8]);
        put_u16(16'h4949, 1'b0);
        send_file();
    endtask

    task automatic test_random_files();
        int b0;
        b0 = bytes_sent;
        while (bytes_sent - b0 < 60)
        begin
            make_random_file();
            send_file();
        end
    endtask

    task automatic test_drain_pause();
        make_random_file();
        send_file();
        // hold off until every pending result is out
        wait_drained();
        make_random_file();
        send_file();
    endtask

    task automatic test_steady_flow();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (2)
        begin
            make_random_file();
            send_file();
        end
    endtask

    initial
    begin
        restart_file();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_marker_errors();
        test_exif_parsing();
        test_random_files();
        test_drain_pause();
        test_steady_flow();
        wait_drained();
        repeat (8) @(posedge clk);
        $display("Streamed %0d files (%0d bytes): marker errors, Exif header cases, random files",
                 files_sent, bytes_sent);
        $display("Checked %0d results, %0d mismatching fields", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/jexif_pkg.sv
rtl/jexif_parser.sv
rtl/jexif_out_reg.sv
rtl/jpeg_exif_orientation_parser_core.sv
dv/tb.sv
